/* hw/rtl/assert_macros.svh */
// Assertion shorthands shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PTO_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PTO_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/pto_pkg.sv */
`default_nettype none

package pto_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int COORD_BITS_DEF = 16;

  localparam int IDX_W      = 4;   // point index fields
  localparam int CNT_W      = 5;   // num_points register
  localparam int K_W        = 6;   // internal index / count, holds n and n+1
  localparam int ID_W       = 12;  // triple id
  localparam int COORD_IN_W = 16;  // coordinate ports
  localparam int ORI_W      = 2;
  localparam int NUM_MIN    = 3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_ROW   = 1'b1;

  localparam logic signed [ORI_W-1:0] ORI_POS = 2'sb01;
  localparam logic signed [ORI_W-1:0] ORI_NEG = 2'sb11;

  typedef enum logic [1:0] {
    TK_I,    // fetch first point
    TK_J,    // fetch second point
    TK_K,    // fetch third point, produces a result
    TK_ERR   // invalid row, produces the error result
  } tok_kind_t;

  typedef struct packed {
    logic             valid;
    tok_kind_t        kind;
    logic [K_W-1:0]   k;
    logic [ID_W-1:0]  id;
    logic             last;
  } tok_t;

endpackage

`default_nettype wire

/* hw/rtl/pto_ram.sv */
`default_nettype none

module pto_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/pto_seq.sv */
`default_nettype none

module pto_seq #(
  parameter int MAX_POINTS = pto_pkg::MAX_POINTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [pto_pkg::CNT_W-1:0]     cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          operation,
  input  wire logic [pto_pkg::IDX_W-1:0]     point_index,
  input  wire logic [pto_pkg::IDX_W-1:0]     second_index,
  input  wire logic                          adv,
  output logic                               ram_we,
  output logic [$clog2(MAX_POINTS)-1:0]      ram_waddr,
  output logic [$clog2(MAX_POINTS)-1:0]      ram_raddr,
  output pto_pkg::tok_t                      iss
);
  import pto_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);

  typedef enum logic [2:0] {S_IDLE, S_ERR, S_PI, S_PJ, S_PK} state_t;

  state_t          state;
  logic [CNT_W-1:0] num_points;
  logic [K_W-1:0]  i_r, j_r, jj_r, n_r, k;
  logic [ID_W-1:0] id, prod_a, jjn;

  logic [K_W-1:0]  n_eff, pi6, sj6, k_next, k_first;
  logic [ID_W-1:0] nm1, nm2;
  logic            in_acc, bad, k_done;

  // Next index at or above s that is neither a nor b.
  function automatic logic [K_W-1:0] skip_two(logic [K_W-1:0] s, logic [K_W-1:0] a,
                                             logic [K_W-1:0] b);
    logic [K_W-1:0] r;
    r = s;
    if (r == a || r == b) r = r + K_W'(1);
    if (r == a || r == b) r = r + K_W'(1);
    return r;
  endfunction

  always_comb begin
    if (K_W'(num_points) < K_W'(NUM_MIN)) begin
      n_eff = K_W'(NUM_MIN);
    end else if (K_W'(num_points) > K_W'(MAX_POINTS)) begin
      n_eff = K_W'(MAX_POINTS);
    end else begin
      n_eff = K_W'(num_points);
    end
  end

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign pi6      = K_W'(point_index);
  assign sj6      = K_W'(second_index);
  assign bad      = (pi6 >= n_eff) || (sj6 >= n_eff) || (pi6 == sj6);

  assign k_first = skip_two('0, i_r, j_r);
  assign k_next  = skip_two(k + K_W'(1), i_r, j_r);
  assign k_done  = (k_next >= n_r);

  assign nm1 = ID_W'(n_r) - ID_W'(1);
  assign nm2 = ID_W'(n_r) - ID_W'(2);

  assign ram_we    = in_acc && (operation == OP_WRITE) && (pi6 < K_W'(MAX_POINTS));
  assign ram_waddr = pi6[AW-1:0];

  always_comb begin
    case (state)
      S_PI:    ram_raddr = i_r[AW-1:0];
      S_PJ:    ram_raddr = j_r[AW-1:0];
      default: ram_raddr = k[AW-1:0];
    endcase
  end

  always_comb begin
    iss.valid = adv && (state inside {S_ERR, S_PI, S_PJ, S_PK});
    iss.k     = k;
    iss.id    = id;
    iss.last  = 1'b0;
    case (state)
      S_PI: begin
        iss.kind = TK_I;
      end
      S_PJ: begin
        iss.kind = TK_J;
      end
      S_PK: begin
        iss.kind = TK_K;
        iss.last = k_done;
      end
      default: begin
        iss.kind = TK_ERR;
        iss.k    = '0;
        iss.id   = '0;
        iss.last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      num_points <= CNT_W'(NUM_MIN);
    end else begin
      if (cfg_we) begin
        num_points <= cfg_wdata;
      end
      case (state)
        S_IDLE: begin
          if (in_acc && operation == OP_ROW) begin
            i_r   <= pi6;
            j_r   <= sj6;
            jj_r  <= (sj6 > pi6) ? sj6 - K_W'(1) : sj6;
            n_r   <= n_eff;
            state <= bad ? S_ERR : S_PI;
          end
        end
        S_ERR: begin
          if (adv) state <= S_IDLE;
        end
        S_PI: begin
          if (adv) begin
            prod_a <= nm1 * nm2;
            jjn    <= ID_W'(jj_r) * nm2;
            k      <= k_first;
            state  <= S_PJ;
          end
        end
        S_PJ: begin
          if (adv) begin
            id    <= ID_W'(i_r) * prod_a + jjn;
            state <= S_PK;
          end
        end
        S_PK: begin
          if (adv) begin
            id <= id + ID_W'(1);
            k  <= k_next;
            if (k_done) state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/pto_dp.sv */
`default_nettype none

module pto_dp #(
  parameter int COORD_BITS = pto_pkg::COORD_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire pto_pkg::tok_t                       iss,
  input  wire logic [2*COORD_BITS-1:0]             rd_data,
  output logic                                     adv,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [pto_pkg::ID_W-1:0]                 triple_id,
  output logic [pto_pkg::IDX_W-1:0]                third_index,
  output logic signed [pto_pkg::ORI_W-1:0]         orientation,
  output logic                                     error,
  output logic                                     last
);
  import pto_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  tok_t                    s1_tok, s2_tok, s3_tok;
  logic [COORD_BITS-1:0]   ax, ay, rx, ry;
  logic signed [DW-1:0]    dx, dy, ux, uy, vx, vy;
  logic signed [PW-1:0]    p1, p2;

  // Whole pipeline moves together; the RAM read is gated by the same enable.
  assign adv = !out_valid || out_ready;

  assign rx = rd_data[COORD_BITS-1:0];
  assign ry = rd_data[2*COORD_BITS-1:COORD_BITS];
  assign dx = $signed({1'b0, rx}) - $signed({1'b0, ax});
  assign dy = $signed({1'b0, ry}) - $signed({1'b0, ay});

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tok.valid <= 1'b0;
      s2_tok.valid <= 1'b0;
      s3_tok.valid <= 1'b0;
      out_valid    <= 1'b0;
    end else if (adv) begin
      // stage 1: point data from RAM
      s1_tok <= iss;
      // stage 2: differences relative to the first point
      s2_tok <= s1_tok;
      vx     <= dx;
      vy     <= dy;
      if (s1_tok.valid && s1_tok.kind == TK_I) begin
        ax <= rx;
        ay <= ry;
      end
      if (s1_tok.valid && s1_tok.kind == TK_J) begin
        ux <= dx;
        uy <= dy;
      end
      // stage 3: cross product terms
      s3_tok <= s2_tok;
      p1     <= ux * vy;
      p2     <= uy * vx;
      // output register
      out_valid   <= s3_tok.valid && (s3_tok.kind == TK_K || s3_tok.kind == TK_ERR);
      triple_id   <= s3_tok.id;
      third_index <= s3_tok.k[IDX_W-1:0];
      error       <= (s3_tok.kind == TK_ERR);
      last        <= s3_tok.last;
      if (s3_tok.kind == TK_ERR) begin
        orientation <= '0;
      end else begin
        orientation <= (p1 > p2) ? ORI_POS : ORI_NEG;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/point_triple_orientation.sv */
// Write beat: stored, no result; next beat taken the following cycle.
// Row beat: results pass the RAM read, difference, product and output registers,
// one result per cycle unless out_ready stalls (one point read and one cross
// product per cycle); the I, J and K states keep it busy until the row is done.
// Invalid row: single error result, busy in the error state until it is issued.
// Reset clears control and sets num_points to 3; point store is not cleared.
`default_nettype none
`include "assert_macros.svh"

module point_triple_orientation #(
  parameter int MAX_POINTS = pto_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = pto_pkg::COORD_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [pto_pkg::CNT_W-1:0]           cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                operation,
  input  wire logic [pto_pkg::IDX_W-1:0]           point_index,
  input  wire logic [pto_pkg::IDX_W-1:0]           second_index,
  input  wire logic [pto_pkg::COORD_IN_W-1:0]      coord_x,
  input  wire logic [pto_pkg::COORD_IN_W-1:0]      coord_y,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [pto_pkg::ID_W-1:0]                 triple_id,
  output logic [pto_pkg::IDX_W-1:0]                third_index,
  output logic signed [pto_pkg::ORI_W-1:0]         orientation,
  output logic                                     error,
  output logic                                     last
);
  import pto_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int RW = 2 * COORD_BITS;

  logic            adv, ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [RW-1:0]   ram_wdata, ram_rdata;
  tok_t            iss;

  assign ram_wdata = {COORD_BITS'(coord_y), COORD_BITS'(coord_x)};

  pto_seq #(
    .MAX_POINTS (MAX_POINTS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .point_index  (point_index),
    .second_index (second_index),
    .adv          (adv),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_raddr    (ram_raddr),
    .iss          (iss)
  );

  pto_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (adv),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pto_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .iss         (iss),
    .rd_data     (ram_rdata),
    .adv         (adv),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .triple_id   (triple_id),
    .third_index (third_index),
    .orientation (orientation),
    .error       (error),
    .last        (last)
  );

  `PTO_ASSERT_IMP(a_err_is_last, clk, rst, out_valid && error, last && triple_id == '0, "error beat must be last with zero id")
  `PTO_ASSERT_IMP(a_ori_sign, clk, rst, out_valid && !error, orientation == ORI_POS || orientation == ORI_NEG, "orientation must be +1 or -1")
  `PTO_ASSERT_IMP(a_wr_idle, clk, rst, ram_we, in_valid && in_ready, "point store written outside an accepted write beat")
  `PTO_ASSERT_NXT(a_iss_busy, clk, rst, iss.valid && !iss.last, !in_ready, "row sequencer went idle mid-row")

endmodule

`default_nettype wire

/* dv/point_triple_orientation_test.sv */
`default_nettype none

module point_triple_orientation_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pto_pkg::*;

  localparam int NPTS        = MAX_POINTS_DEF;
  localparam int SETTLE_WAIT = 24;     // covers busy time plus result latency
  localparam int DRAIN_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 45;

  typedef struct {
    logic [ID_W-1:0]         id;
    logic [IDX_W-1:0]        third;
    logic signed [ORI_W-1:0] sign;
    logic                    err;
    logic                    fin;
  } sign_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CNT_W-1:0]      cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic                  operation;
  logic [IDX_W-1:0]      point_index;
  logic [IDX_W-1:0]      second_index;
  logic [COORD_IN_W-1:0] coord_x;
  logic [COORD_IN_W-1:0] coord_y;
  logic                  out_valid;
  logic                  out_ready;
  logic [ID_W-1:0]       triple_id;
  logic [IDX_W-1:0]      third_index;
  logic signed [ORI_W-1:0] orientation;
  logic                  error;
  logic                  last;

  // shadow of the block: point store and point count register
  logic [COORD_IN_W-1:0] shadow_x [NPTS];
  logic [COORD_IN_W-1:0] shadow_y [NPTS];
  logic [CNT_W-1:0]      shadow_count;
  sign_result_t          pending_signs[$];

  int  mismatches;
  int  writes_seen;
  int  rows_seen;
  int  rows_rejected;
  int  results_checked;
  int  count_settings;
  int  active_n;
  bit  sender_burst;
  bit  sink_burst;
  int  hold_requests;
  int  holds_served;
  int  hold_left;
  int  sink_wait;

  point_triple_orientation DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .point_index (point_index),
    .second_index(second_index),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .triple_id   (triple_id),
    .third_index (third_index),
    .orientation (orientation),
    .error       (error),
    .last        (last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int clamp_count(logic [CNT_W-1:0] raw);
    if (raw < NUM_MIN) return NUM_MIN;
    if (raw > NPTS) return NPTS;
    return int'(raw);
  endfunction

  function automatic int pick_gap(bit burst);
    if (burst) return 0;
    return $urandom_range(0, 14);
  endfunction

  // Mix of corners, tiny and grid values so duplicates and collinear points show up.
  function automatic logic [COORD_IN_W-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      1: return COORD_IN_W'($urandom_range(0, 3));
      2: return COORD_IN_W'($urandom_range(0, 4) * 16'h1000);
      default: return COORD_IN_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Strict left turn of c relative to the directed line a -> b.
  function automatic bit turns_left(int a, int b, int c);
    longint ux, uy, vx, vy;
    ux = longint'(shadow_x[b]) - longint'(shadow_x[a]);
    uy = longint'(shadow_y[b]) - longint'(shadow_y[a]);
    vx = longint'(shadow_x[c]) - longint'(shadow_x[a]);
    vy = longint'(shadow_y[c]) - longint'(shadow_y[a]);
    return ux * vy > uy * vx;
  endfunction

  task automatic predict_row(input int i, input int j);
    sign_result_t r;
    int n, jj, base, cnt, final_k;
    n = clamp_count(shadow_count);
    rows_seen++;
    if (i >= n || j >= n || i == j) begin
      r = '{id: '0, third: '0, sign: '0, err: 1'b1, fin: 1'b1};
      pending_signs.push_back(r);
      rows_rejected++;
      return;
    end
    jj = (j > i) ? j - 1 : j;
    base = i * (n - 1) * (n - 2) + jj * (n - 2);
    final_k = n - 1;
    while (final_k == i || final_k == j) final_k--;
    cnt = 0;
    for (int k = 0; k < n; k++) begin
      if (k == i || k == j) continue;
      r.id    = ID_W'(base + cnt);
      r.third = IDX_W'(k);
      r.sign  = turns_left(i, j, k) ? ORI_POS : ORI_NEG;
      r.err   = 1'b0;
      r.fin   = (k == final_k);
      pending_signs.push_back(r);
      cnt++;
    end
  endtask

  // input side: every accepted write beat and register write goes into the shadow; rows are predicted
  always @(posedge clk) begin
    if (rst) begin
      shadow_count = CNT_W'(NUM_MIN);
    end else begin
      if (cfg_we) shadow_count = cfg_wdata;
      if (in_valid && in_ready) begin
        if (operation == OP_WRITE) begin
          shadow_x[point_index] = coord_x;
          shadow_y[point_index] = coord_y;
          writes_seen++;
        end else begin
          predict_row(int'(point_index), int'(second_index));
        end
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin : result_check
    sign_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_checked++;
      if (pending_signs.size() == 0) begin
        report_mismatch("result with nothing pending, triple_id", 16'(triple_id), '0);
      end else begin
        want = pending_signs.pop_front();
        check_field("triple_id", 16'(triple_id), 16'(want.id));
        check_field("third_index", 16'(third_index), 16'(want.third));
        check_field("orientation", 16'(orientation), 16'(want.sign));
        check_field("error", 16'(error), 16'(want.err));
        check_field("last", 16'(last), 16'(want.fin));
      end
    end
  end

  // output side: random stalls per beat, plus long hold-offs on request
  always @(posedge clk) begin : result_sink
    int gap;
    if (rst) begin
      out_ready    <= 1'b0;
      sink_wait    <= 0;
      hold_left    <= 0;
      holds_served <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left    <= HOLD_CYCLES;
      out_ready    <= 1'b0;
    end else if (out_ready) begin
      if (out_valid) begin
        gap = pick_gap(sink_burst);
        out_ready <= (gap == 0);
        sink_wait <= gap;
      end
    end else if (sink_wait <= 1) begin
      out_ready <= 1'b1;
    end else begin
      sink_wait <= sink_wait - 1;
    end
  end

  // Leaves valid high on return, so a back-to-back beat needs no drop.
  task automatic send_beat(input logic op, input int pi, input int si,
                           input logic [COORD_IN_W-1:0] x,
                           input logic [COORD_IN_W-1:0] y);
    int gap;
    gap = pick_gap(sender_burst);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    point_index  <= IDX_W'(pi);
    second_index <= IDX_W'(si);
    coord_x      <= x;
    coord_y      <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_row(input int i, input int j);
    send_beat(OP_ROW, i, j, rand_coord(), rand_coord());
  endtask

  task automatic send_good_row();
    int i, j;
    i = $urandom_range(0, active_n - 1);
    j = $urandom_range(0, active_n - 2);
    if (j >= i) j++;
    send_row(i, j);
  endtask

  task automatic settle();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    @(negedge clk);
    while (pending_signs.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic set_point_count(input logic [CNT_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    active_n = clamp_count(value);
    count_settings++;
  endtask

  // Fills the whole store first so no row ever reads an unwritten point.
  task automatic test_point_load();
    send_beat(OP_WRITE, 0, 15, 16'h0000, 16'h0000);
    send_beat(OP_WRITE, 1, 0, 16'hFFFF, 16'hFFFF);
    send_beat(OP_WRITE, 2, 5, 16'h0000, 16'hFFFF);
    send_beat(OP_WRITE, 3, 10, 16'hFFFF, 16'h0000);
    for (int p = 4; p < NPTS; p++)
      send_beat(OP_WRITE, p, $urandom_range(0, 15), rand_coord(), rand_coord());
  endtask

  // count is still at its reset value of three here
  task automatic test_reset_rows();
    send_row(0, 1);
    send_row(1, 0);
    send_row(2, 0);
    send_row(1, 1);
    send_row(3, 0);
    send_row(0, 15);
    send_row(15, 15);
    // midpoint of the diagonal: collinear, so not a left turn
    send_beat(OP_WRITE, 2, 0, 16'h8000, 16'h8000);
    send_row(0, 1);
  endtask

  task automatic test_random_phases();
    int phase_counts[10];
    phase_counts = '{31, 0, 16, 5, 1, 17, 2, 9, 12, 3};
    foreach (phase_counts[ph]) begin
      set_point_count(CNT_W'(phase_counts[ph]));
      sender_burst = (ph % 4 == 3);
      sink_burst  <= (ph % 3 == 2);
      for (int it = 0; it < PHASE_ITEMS; it++) begin
        case ($urandom_range(0, 7))
          0, 1: send_beat(OP_WRITE, $urandom_range(0, 15), $urandom_range(0, 15),
                          rand_coord(), rand_coord());
          2: send_row($urandom_range(0, 15), $urandom_range(0, 15));
          default: send_good_row();
        endcase
      end
    end
    sender_burst = 0;
    sink_burst  <= 1'b0;
  endtask

  // receiver holds off while rows keep coming, so the block must stall its input
  task automatic test_input_stall();
    set_point_count(CNT_W'(16));
    hold_requests <= hold_requests + 1;
    sender_burst = 1;
    send_row(15, 14);
    for (int it = 0; it < 29; it++) send_good_row();
    sender_burst = 0;
    settle();
  endtask

  initial begin : watchdog
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    operation     <= OP_WRITE;
    point_index   <= '0;
    second_index  <= '0;
    coord_x       <= '0;
    coord_y       <= '0;
    hold_requests <= 0;
    sink_burst    <= 1'b0;
    sender_burst   = 0;
    active_n       = NUM_MIN;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_point_load();
    test_reset_rows();
    test_random_phases();
    test_input_stall();
    settle();

    if (pending_signs.size() != 0)
      report_mismatch("results never delivered", 16'(pending_signs.size()), '0);
    $display("Covered %0d point writes and %0d rows (%0d rejected) over %0d count settings,",
             writes_seen, rows_seen, rows_rejected, count_settings);
    $display("with %0d orientation results checked and %0d mismatches.",
             results_checked, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* point_triple_orientation.f */
+incdir+hw/rtl
hw/rtl/pto_pkg.sv
hw/rtl/pto_ram.sv
hw/rtl/pto_seq.sv
hw/rtl/pto_dp.sv
hw/rtl/point_triple_orientation.sv
dv/point_triple_orientation_test.sv
